@@ hdl/assert_macros.svh @@
// Assertion macros shared by the sample FIFO top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/asfc_pkg.sv @@
// Package for the audio sample FIFO: sizes, mode codes, states, control structs
// and float conversion functions. No dependencies.
package asfc_pkg;
  localparam int FifoDepth = 4096;
  localparam int AddrW = $clog2(FifoDepth);
  localparam int CountW = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    MODE_WR_FLOAT = 3'd0,
    MODE_WR_PCM   = 3'd1,
    MODE_WR_ZERO  = 3'd2,
    MODE_RD_FLOAT = 3'd3,
    MODE_RD_PCM   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic issue;
    logic rd_pcm;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

  // Exact float of pcm / 32768.
  function automatic logic [31:0] pcm_to_float(input logic signed [15:0] p);
    logic        s;
    logic [15:0] m;
    logic [4:0]  lz;
    logic [15:0] n;
    s = p[15];
    m = s ? 16'(-p) : p;
    lz = 5'd0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i] && lz == 5'd0) lz = 5'(16 - i);
    end
    if (m == 16'd0) begin
      pcm_to_float = 32'd0;
    end else begin
      n = m << (lz - 5'd1);
      // value = m * 2^-15; msb at bit (16-lz) -> exponent (16-lz)-15
      pcm_to_float = {s, 8'(8'd128 - {3'd0, lz}), n[14:0], 8'd0};
    end
  endfunction

  // Clamp to [-1,1], times 32767 in float32 (round to nearest even), truncate.
  function automatic logic [15:0] float_to_pcm(input logic [31:0] f);
    logic        s;
    logic [7:0]  e;
    logic [23:0] m;
    logic [39:0] prod;
    logic [5:0]  lead;
    logic [39:0] keep_mask;
    logic [39:0] rnd;
    logic [39:0] q;
    logic [15:0] mag;
    int          sh;
    s = f[31];
    e = f[30:23];
    m = {1'b1, f[22:0]};
    mag = 16'd0;
    if (e == 8'hff && f[22:0] != 23'd0) begin
      mag = 16'd0;
    end else if (e >= 8'd127) begin
      mag = 16'd32767;
    end else if (e < 8'd103) begin
      mag = 16'd0;
    end else begin
      prod = 40'(m) * 40'd32767;
      lead = 6'd0;
      for (int i = 38; i >= 0; i--) begin
        if (prod[i] && lead == 6'd0) lead = 6'(i);
      end
      keep_mask = ~((40'd1 << (lead - 6'd23)) - 40'd1);
      rnd = prod & keep_mask;
      if (prod[lead - 6'd24] &&
          (((prod & ~keep_mask) & ~(40'd1 << (lead - 6'd24))) != 40'd0 ||
           prod[lead - 6'd23]))
        rnd = rnd + (40'd1 << (lead - 6'd23));
      sh = 23 + 127 - int'(e);
      q = rnd >> sh;
      mag = q[15:0];
    end
    float_to_pcm = s ? 16'(-mag) : mag;
  endfunction
endpackage

@@ hdl/asfc_ctrl.sv @@
// Controller state machine for the sample FIFO.
// Depends on asfc_pkg.
module asfc_ctrl import asfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] mode,
  input  stat_t      stat,
  output ctrl_t      ctrl,
  output logic       busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctrl.issue = 1'b1;
          case (mode)
            MODE_WR_FLOAT, MODE_WR_PCM, MODE_WR_ZERO: begin
              ctrl.push = !stat.full;
              state_next = ST_DONE;
            end
            MODE_RD_FLOAT, MODE_RD_PCM: begin
              ctrl.pop = !stat.empty;
              ctrl.rd_pcm = (mode == MODE_RD_PCM);
              state_next = ST_READ;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

@@ hdl/asfc_datapath.sv @@
// Datapath: sample memory, pointers, count and float/PCM conversion on write and read.
// Depends on asfc_pkg.
module asfc_datapath import asfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  input  logic [2:0]         mode,
  input  logic [31:0]        float_sample,
  input  logic signed [15:0] pcm_sample,
  output stat_t              stat,
  output logic               done,
  output logic               accepted,
  output logic [31:0]        read_float,
  output logic signed [15:0] read_pcm,
  output logic [12:0]        fill_level
);
  logic [31:0]       mem [FifoDepth];
  logic [AddrW-1:0]  rd_ptr, wr_ptr;
  logic [CountW-1:0] count;
  logic [31:0]       wdata, rdata;
  logic              s1_valid, s1_ok, s1_pop, s1_pcm;

  always_comb begin
    case (mode)
      MODE_WR_FLOAT: wdata = float_sample;
      MODE_WR_PCM:   wdata = pcm_to_float(pcm_sample);
      default:       wdata = 32'd0;
    endcase
  end

  assign stat.full  = (count == CountW'(FifoDepth));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (ctrl.push) mem[wr_ptr] <= wdata;
    rdata <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0; wr_ptr <= '0; count <= '0;
      s1_valid <= 1'b0; done <= 1'b0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= (wr_ptr == AddrW'(FifoDepth - 1)) ? '0 : wr_ptr + 1'b1;
        count <= count + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == AddrW'(FifoDepth - 1)) ? '0 : rd_ptr + 1'b1;
        count <= count - 1'b1;
      end
      s1_valid <= ctrl.issue;
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      s1_ok <= ctrl.push | ctrl.pop;
      s1_pop <= ctrl.pop;
      s1_pcm <= ctrl.rd_pcm;
    end
    if (s1_valid) begin
      accepted <= s1_ok;
      read_float <= (s1_pop && !s1_pcm) ? rdata : 32'd0;
      read_pcm <= (s1_pop && s1_pcm) ? float_to_pcm(rdata) : 16'sd0;
      fill_level <= 13'(count);
    end
  end
endmodule

@@ hdl/audio_sample_fifo_with_conversion_core.sv @@
// Top level of the audio sample FIFO with float/PCM conversion.
// Depends on asfc_pkg, asfc_ctrl, asfc_datapath, assert_macros.svh.
//
// Usage:
//   Raise start with mode, float_sample and pcm_sample; the beat is taken at
//   a rising edge where start is high and busy is low.
//   Modes: write float, write pcm16 (scaled by 1/32768), write silence,
//   read float, read pcm16 (clamped, times 32767, truncated).
//   Exactly one result per beat, shown for one cycle with done high; the beat
//   passes the s1 registers and then the output registers before it shows.
//   busy stays high through ST_DONE after a write or unused mode and through
//   ST_READ and ST_DONE after a read, so a new beat is taken only once the
//   controller is back in ST_IDLE.
//   A write to a full FIFO or a read of an empty one returns accepted low.
//   fill_level is the count after the beat.
//   Reset empties the FIFO; memory contents are not cleared.
//   The receiver cannot stall: done is a one-cycle strobe.
`include "assert_macros.svh"
module audio_sample_fifo_with_conversion_core import asfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic [31:0]        float_sample,
  input  logic signed [15:0] pcm_sample,
  output logic               done,
  output logic               accepted,
  output logic [31:0]        read_float,
  output logic signed [15:0] read_pcm,
  output logic [12:0]        fill_level
);
  ctrl_t ctrl;
  stat_t stat;

  asfc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(mode),
    .stat(stat), .ctrl(ctrl), .busy(busy)
  );

  asfc_datapath u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .mode(mode),
    .float_sample(float_sample), .pcm_sample(pcm_sample),
    .stat(stat), .done(done), .accepted(accepted),
    .read_float(read_float), .read_pcm(read_pcm), .fill_level(fill_level)
  );

  `ASSERT_CLK(a_push_not_full, ctrl.push |-> !stat.full, "push while full")
  `ASSERT_CLK(a_pop_not_empty, ctrl.pop |-> !stat.empty, "pop while empty")
  `ASSERT_CLK(a_done_after_issue, ctrl.issue |=> ##1 done, "missing result")
  `ASSERT_CLK_RST(a_rst_idle, rst |=> !busy, "busy after reset")
endmodule
